FILE: hw/rtl/sdtec_pkg.sv
package sdtec_pkg;

  // numerator and divisor magnitudes seen by the divide units
  localparam int NUM_W   = 84;
  localparam int DEN_W   = 51;
  localparam int QUO_W   = 32;
  // divide unit stages: input stage, one stage per quotient bit, output stage
  localparam int DIV_LAT = QUO_W + 2;

  localparam int SCREEN_W_DEF = 4096;
  localparam int SCREEN_H_DEF = 4096;

  // configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_LEFT   = 3'd1;
  localparam logic [2:0] REG_RIGHT  = 3'd2;
  localparam logic [2:0] REG_BOTTOM = 3'd3;
  localparam logic [2:0] REG_TOP    = 3'd4;
  localparam logic [2:0] REG_NEAR   = 3'd5;
  localparam logic [2:0] REG_FAR    = 3'd6;

  localparam logic        MODE_PERSP = 1'b0;
  localparam logic        MODE_ORTHO = 1'b1;

  // register reset values
  localparam logic signed [31:0] RST_LEFT   = -32'sd7565;
  localparam logic signed [31:0] RST_RIGHT  = 32'sd7565;
  localparam logic signed [31:0] RST_BOTTOM = -32'sd4728;
  localparam logic signed [31:0] RST_TOP    = 32'sd4728;
  localparam logic signed [31:0] RST_NEAR   = 32'sd8192;
  localparam logic signed [31:0] RST_FAR    = 32'sd67108864;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // one rounded, saturated division request
  typedef struct packed {
    logic [NUM_W-1:0] num_mag;
    logic             num_neg;
    logic             num_zero;
    logic [DEN_W-1:0] den_mag;
    logic             den_neg;
  } div_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               fault;
  } div_res_t;

endpackage

FILE: hw/rtl/sdtec_div.sv
module sdtec_div (
  input  logic                clk,
  input  logic                en,
  input  sdtec_pkg::div_req_t req,
  output sdtec_pkg::div_res_t res
);
  import sdtec_pkg::*;

  localparam int HI_W = NUM_W - QUO_W;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             neg_num;
    logic             dz;
    logic             ovf;
  } div_stage_t;

  div_stage_t stg [QUO_W+1];

  logic [NUM_W-1:0] num_rnd;
  logic [HI_W-1:0]  num_hi;
  div_stage_t       stg0_next;

  // round to nearest, then check that the quotient fits in 32 bits
  always_comb begin
    num_rnd = req.num_mag + NUM_W'(req.den_mag >> 1);
    num_hi  = num_rnd[NUM_W-1:QUO_W];
    stg0_next.rem     = num_hi[DEN_W-1:0];
    stg0_next.low     = num_rnd[QUO_W-1:0];
    stg0_next.quo     = '0;
    stg0_next.den     = req.den_mag;
    stg0_next.neg     = !req.num_zero && (req.num_neg ^ req.den_neg);
    stg0_next.neg_num = req.num_neg;
    stg0_next.dz      = (req.den_mag == '0);
    stg0_next.ovf     = (num_hi >= HI_W'(req.den_mag));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= stg0_next;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 1; k <= QUO_W; k++) begin : g_bit
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    div_stage_t     stg_next;

    always_comb begin
      trial    = {stg[k-1].rem, stg[k-1].low[QUO_W-1]};
      diff     = trial - {1'b0, stg[k-1].den};
      ge       = (trial >= {1'b0, stg[k-1].den});
      stg_next = stg[k-1];
      stg_next.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      stg_next.low = {stg[k-1].low[QUO_W-2:0], 1'b0};
      stg_next.quo = {stg[k-1].quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= stg_next;
      end
    end
  end

  div_stage_t last;
  logic       over;
  div_res_t   res_next;

  // sign, saturation and zero divisor handling
  always_comb begin
    last = stg[QUO_W];
    over = last.ovf || (last.neg ? (last.quo > 32'h8000_0000) : last.quo[QUO_W-1]);
    if (last.dz) begin
      res_next.value = last.neg_num ? SAT_MIN : SAT_MAX;
      res_next.fault = 1'b1;
    end else if (over) begin
      res_next.value = last.neg ? SAT_MIN : SAT_MAX;
      res_next.fault = 1'b1;
    end else begin
      res_next.value = last.neg ? -$signed(last.quo) : $signed(last.quo);
      res_next.fault = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

FILE: hw/rtl/screen_depth_to_eye_coord.sv
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------------
// input    | in_valid  | in_stall  | pixel_x, pixel_y, depth_value
// output   | out_valid | out_stall | eye_x, eye_y, eye_z, range_fault
// config   | cfg_we    | -         | cfg_addr, cfg_data
//
// one item per cycle unless out_stall holds the pipeline; its depth comes mainly from the two
// chained bit-per-stage divide pipelines (eye z first, then eye x and y).
// reset clears the valid bits and loads the frustum registers.
// the whole pipeline holds while a result waits under out_stall.
module screen_depth_to_eye_coord #(
  parameter int SCREEN_WIDTH  = sdtec_pkg::SCREEN_W_DEF,
  parameter int SCREEN_HEIGHT = sdtec_pkg::SCREEN_H_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        pixel_x,
  input  logic [11:0]        pixel_y,
  input  logic [16:0]        depth_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] eye_x,
  output logic signed [31:0] eye_y,
  output logic signed [31:0] eye_z,
  output logic               range_fault,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_data
);
  import sdtec_pkg::*;

  localparam logic signed [18:0] SCR_W = 19'(SCREEN_WIDTH);
  localparam logic signed [18:0] SCR_H = 19'(SCREEN_HEIGHT);
  localparam int TOTAL = 2 * DIV_LAT + 4;

  typedef struct packed {
    logic               mode;
    logic signed [51:0] ax;
    logic signed [51:0] ay;
    logic signed [50:0] nw;
    logic signed [50:0] nh;
    logic signed [52:0] oxn;
    logic signed [52:0] oyn;
  } zside_t;

  typedef struct packed {
    logic signed [31:0] ez;
    logic               fz;
  } xside_t;

  // configuration registers
  logic               proj_mode;
  logic signed [31:0] frustum_left, frustum_right, frustum_bottom, frustum_top;
  logic signed [31:0] near_plane, far_plane;

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_mode      <= MODE_PERSP;
      frustum_left   <= RST_LEFT;
      frustum_right  <= RST_RIGHT;
      frustum_bottom <= RST_BOTTOM;
      frustum_top    <= RST_TOP;
      near_plane     <= RST_NEAR;
      far_plane      <= RST_FAR;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:   proj_mode      <= cfg_data[0];
        REG_LEFT:   frustum_left   <= cfg_data;
        REG_RIGHT:  frustum_right  <= cfg_data;
        REG_BOTTOM: frustum_bottom <= cfg_data;
        REG_TOP:    frustum_top    <= cfg_data;
        REG_NEAR:   near_plane     <= cfg_data;
        REG_FAR:    far_plane      <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             en;
  logic             acc;
  logic [TOTAL-1:0] vld;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign acc      = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[TOTAL-2:0], acc};
      out_valid <= vld[TOTAL-1];
    end
  end

  // stage 1: screen mapping and front products
  logic signed [18:0] sx_c, sy_c;
  logic signed [17:0] dv_s;
  logic signed [32:0] dxr_c, dyr_c, fnr_c, lr_c, tb_c;

  logic               mode1;
  logic signed [31:0] n1, f1;
  logic signed [51:0] ax1, ay1, lrw1, tbh1;
  logic signed [50:0] fd1, nw1, nh1;
  logic signed [63:0] nf1;

  always_comb begin
    sx_c  = signed'({6'd0, pixel_x, 1'b0}) - SCR_W;
    sy_c  = signed'({6'd0, pixel_y, 1'b0}) - SCR_H;
    dv_s  = signed'({1'b0, depth_value});
    dxr_c = 33'(frustum_right) - 33'(frustum_left);
    dyr_c = 33'(frustum_top) - 33'(frustum_bottom);
    fnr_c = 33'(far_plane) - 33'(near_plane);
    lr_c  = 33'(frustum_left) + 33'(frustum_right);
    tb_c  = 33'(frustum_top) + 33'(frustum_bottom);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= proj_mode;
      n1    <= near_plane;
      f1    <= far_plane;
      ax1   <= sx_c * dxr_c;
      ay1   <= sy_c * dyr_c;
      lrw1  <= lr_c * SCR_W;
      tbh1  <= tb_c * SCR_H;
      fd1   <= fnr_c * dv_s;
      nw1   <= near_plane * SCR_W;
      nh1   <= near_plane * SCR_H;
      nf1   <= near_plane * far_plane;
    end
  end

  // stage 2: eye z division request and orthographic x, y numerators
  logic signed [51:0] denp_c, ozn_c;
  logic [63:0]        nfm_c;
  div_req_t           zreq_next, zreq;
  zside_t             zs_next;
  zside_t             zside [DIV_LAT+1];
  div_res_t           zres;

  always_comb begin
    denp_c = signed'({f1, 16'd0}) - 52'(fd1);
    ozn_c  = 52'(fd1) + signed'({n1, 16'd0});
    nfm_c  = nf1[63] ? 64'(-nf1) : 64'(nf1);
    if (mode1 == MODE_PERSP) begin
      zreq_next.num_mag  = NUM_W'({nfm_c, 16'd0});
      zreq_next.num_neg  = nf1[63];
      zreq_next.num_zero = (nf1 == '0);
      zreq_next.den_mag  = (f1 == '0) ? '0
                         : DEN_W'(denp_c[51] ? -denp_c : denp_c);
      zreq_next.den_neg  = denp_c[51];
    end else begin
      zreq_next.num_mag  = NUM_W'(ozn_c[51] ? -ozn_c : ozn_c);
      zreq_next.num_neg  = ozn_c[51];
      zreq_next.num_zero = (ozn_c == '0);
      zreq_next.den_mag  = DEN_W'(65536);
      zreq_next.den_neg  = 1'b0;
    end
    zs_next.mode = mode1;
    zs_next.ax   = ax1;
    zs_next.ay   = ay1;
    zs_next.nw   = nw1;
    zs_next.nh   = nh1;
    zs_next.oxn  = 53'(ax1) + 53'(lrw1);
    zs_next.oyn  = 53'(ay1) + 53'(tbh1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zreq     <= zreq_next;
      zside[0] <= zs_next;
      for (int k = 1; k <= DIV_LAT; k++) begin
        zside[k] <= zside[k-1];
      end
    end
  end

  sdtec_div u_div_z (
    .clk (clk),
    .en  (en),
    .req (zreq),
    .res (zres)
  );

  // stage 3: split products of |a| by |eye z|
  zside_t             zo;
  logic [51:0]        axm_c, aym_c;
  logic [31:0]        ezm_c;
  logic [57:0]        pxl3, pxh3, pyl3, pyh3;
  logic               xneg3, xzero3, yneg3, yzero3;
  zside_t             zs3;
  logic signed [31:0] ez3;
  logic               fz3;

  always_comb begin
    zo    = zside[DIV_LAT];
    axm_c = zo.ax[51] ? 52'(-zo.ax) : 52'(zo.ax);
    aym_c = zo.ay[51] ? 52'(-zo.ay) : 52'(zo.ay);
    ezm_c = zres.value[31] ? 32'(-zres.value) : 32'(zres.value);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl3   <= 58'(axm_c[25:0]) * 58'(ezm_c);
      pxh3   <= 58'(axm_c[51:26]) * 58'(ezm_c);
      pyl3   <= 58'(aym_c[25:0]) * 58'(ezm_c);
      pyh3   <= 58'(aym_c[51:26]) * 58'(ezm_c);
      xzero3 <= (zo.ax == '0) || (zres.value == '0);
      yzero3 <= (zo.ay == '0) || (zres.value == '0);
      xneg3  <= zo.ax[51] ^ zres.value[31];
      yneg3  <= zo.ay[51] ^ zres.value[31];
      zs3    <= zo;
      ez3    <= zres.value;
      fz3    <= zres.fault;
    end
  end

  // stage 4: eye x and y division requests
  logic [50:0] nwm_c, nhm_c;
  div_req_t    xreq_next, yreq_next, xreq, yreq;
  xside_t      xs_next;
  xside_t      xside [DIV_LAT+1];
  div_res_t    xres, yres;

  always_comb begin
    nwm_c = zs3.nw[50] ? 51'(-zs3.nw) : 51'(zs3.nw);
    nhm_c = zs3.nh[50] ? 51'(-zs3.nh) : 51'(zs3.nh);
    if (zs3.mode == MODE_PERSP) begin
      xreq_next.num_mag  = (NUM_W'(pxh3) << 26) + NUM_W'(pxl3);
      xreq_next.num_zero = xzero3;
      xreq_next.num_neg  = !xzero3 && xneg3;
      xreq_next.den_mag  = DEN_W'({nwm_c, 1'b0});
      xreq_next.den_neg  = zs3.nw[50];
      yreq_next.num_mag  = (NUM_W'(pyh3) << 26) + NUM_W'(pyl3);
      yreq_next.num_zero = yzero3;
      yreq_next.num_neg  = !yzero3 && yneg3;
      yreq_next.den_mag  = DEN_W'({nhm_c, 1'b0});
      yreq_next.den_neg  = zs3.nh[50];
    end else begin
      xreq_next.num_mag  = NUM_W'(zs3.oxn[52] ? -zs3.oxn : zs3.oxn);
      xreq_next.num_zero = (zs3.oxn == '0);
      xreq_next.num_neg  = zs3.oxn[52];
      xreq_next.den_mag  = DEN_W'({SCR_W, 1'b0});
      xreq_next.den_neg  = 1'b0;
      yreq_next.num_mag  = NUM_W'(zs3.oyn[52] ? -zs3.oyn : zs3.oyn);
      yreq_next.num_zero = (zs3.oyn == '0);
      yreq_next.num_neg  = zs3.oyn[52];
      yreq_next.den_mag  = DEN_W'({SCR_H, 1'b0});
      yreq_next.den_neg  = 1'b0;
    end
    xs_next.ez = ez3;
    xs_next.fz = fz3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xreq     <= xreq_next;
      yreq     <= yreq_next;
      xside[0] <= xs_next;
      for (int k = 1; k <= DIV_LAT; k++) begin
        xside[k] <= xside[k-1];
      end
    end
  end

  sdtec_div u_div_x (
    .clk (clk),
    .en  (en),
    .req (xreq),
    .res (xres)
  );

  sdtec_div u_div_y (
    .clk (clk),
    .en  (en),
    .req (yreq),
    .res (yres)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      eye_x       <= xres.value;
      eye_y       <= yres.value;
      eye_z       <= xside[DIV_LAT].ez;
      range_fault <= xside[DIV_LAT].fz || xres.fault || yres.fault;
    end
  end

  // pipeline checks
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && (vld == '0))
    else $error("pipeline valid bits not cleared by reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved while the pipeline was held");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    en && vld[TOTAL-1] |=> out_valid)
    else $error("item in last stage did not reach the output");

  a_no_accept_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input transfer taken while the output is held");

endmodule
